@@ sv/prbg_pkg.sv @@
`timescale 1ns / 1ps
`default_nettype none

package prbg_pkg;

  // Field widths of the transfer payloads
  localparam int unsigned REQ_TYPE_W = 2;
  localparam int unsigned PRB_IDX_W  = 9;
  localparam int unsigned WIDX_W     = 3;
  localparam int unsigned WORD_W     = 64;
  localparam int unsigned RBG_W      = 19;
  localparam int unsigned RBG_CNT_W  = 5;
  localparam int unsigned OFF_W      = 4;
  localparam int unsigned LP_W       = 3;

  // Configuration port
  localparam int unsigned CFG_IDX_W  = 2;
  localparam int unsigned CFG_DATA_W = 9;

  localparam logic [PRB_IDX_W-1:0] BWP_SIZE_RST  = 9'd275;
  localparam logic [PRB_IDX_W-1:0] BWP_FIRST_RST = 9'd0;
  localparam logic                 RBG_CFG1_RST  = 1'b1;

  // Part-size thresholds of the nominal RBG size table
  localparam logic [PRB_IDX_W-1:0] SIZE_TH0 = 9'd36;
  localparam logic [PRB_IDX_W-1:0] SIZE_TH1 = 9'd72;
  localparam logic [PRB_IDX_W-1:0] SIZE_TH2 = 9'd144;

  typedef enum logic [REQ_TYPE_W-1:0] {
    REQ_INTERVAL = 2'd0,
    REQ_WORD     = 2'd1,
    REQ_RBG      = 2'd2,
    REQ_READ     = 2'd3
  } req_type_e;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_BWP_SIZE  = 2'd0,
    CFG_BWP_FIRST = 2'd1,
    CFG_RBG_CFG1  = 2'd2
  } cfg_idx_e;

  typedef struct packed {
    req_type_e             req_type;
    logic [PRB_IDX_W-1:0]  prb_first;
    logic [PRB_IDX_W-1:0]  prb_end;
    logic [WIDX_W-1:0]     word_index;
    logic [WORD_W-1:0]     grant_word;
  } req_t;

  typedef struct packed {
    logic [RBG_W-1:0]  rbg_bits;
    logic [WORD_W-1:0] prb_word_out;
  } res_t;

  typedef struct packed {
    logic [PRB_IDX_W-1:0] bwp_size;
    logic [PRB_IDX_W-1:0] bwp_first_prb;
    logic                 rbg_config1;
  } cfg_t;

endpackage

`default_nettype wire

@@ sv/prbg_ram.sv @@
`timescale 1ns / 1ps
`default_nettype none

module prbg_ram #(
  parameter int unsigned DEPTH = 5,
  parameter int unsigned AW    = 3
) (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire logic                          rd_en_i,
  input  wire logic [AW-1:0]                 rd_addr_i,
  output logic      [prbg_pkg::WORD_W-1:0]   rd_data_o,
  input  wire logic                          wr_en_i,
  input  wire logic [AW-1:0]                 wr_addr_i,
  input  wire logic [prbg_pkg::WORD_W-1:0]   wr_data_i
);
  import prbg_pkg::*;

  logic [WORD_W-1:0] mem_q [DEPTH];
  logic [WORD_W-1:0] rdata_q;
  logic [DEPTH-1:0]  vld_q;
  logic              rvld_q;

  // Array storage, no reset
  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem_q[wr_addr_i] <= wr_data_i;
    end
    if (rd_en_i) begin
      rdata_q <= mem_q[rd_addr_i];
    end
  end

  // Per-entry valid bits: a never-written word reads as zero
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q  <= '0;
      rvld_q <= 1'b0;
    end else begin
      if (wr_en_i) begin
        vld_q[wr_addr_i] <= 1'b1;
      end
      if (rd_en_i) begin
        rvld_q <= vld_q[rd_addr_i];
      end
    end
  end

  assign rd_data_o = rvld_q ? rdata_q : '0;

endmodule

`default_nettype wire

@@ sv/prbg_map.sv @@
`timescale 1ns / 1ps
`default_nettype none

module prbg_map #(
  parameter int unsigned MAX_PRBS = 275,
  parameter int unsigned MAX_RBGS = 19,
  localparam int unsigned NW = (MAX_PRBS + 63) / 64,
  localparam int unsigned NB = NW * 64
) (
  input  wire prbg_pkg::cfg_t                 cfg_i,
  input  wire prbg_pkg::req_t                 req_i,
  input  wire logic [prbg_pkg::RBG_W-1:0]     mask_i,
  output logic      [prbg_pkg::RBG_W-1:0]     rbg_set_o,
  output logic      [NB-1:0]                  prb_set_o
);
  import prbg_pkg::*;

  // Wide enough for the PRB range plus offset and for every RBG chunk
  localparam int unsigned ZW = ((NB + 16) > (RBG_W * 16)) ? (NB + 16) : (RBG_W * 16);

  logic [PRB_IDX_W-1:0] size_s;
  logic [LP_W-1:0]      lp;
  logic [OFF_W:0]       p_w;
  logic [OFF_W-1:0]     off;
  logic [9:0]           span;
  logic [9:0]           nrbg_raw;
  logic [RBG_CNT_W-1:0] nrbg;
  logic [RBG_W-1:0]     rbg_ok;
  logic [NB-1:0]        prb_ok;

  logic [PRB_IDX_W-1:0] end_c;
  logic [9:0]           r0;
  logic [9:0]           r1;
  logic [RBG_W-1:0]     hit_int;

  logic [NB-1:0]        word_v;
  logic [ZW-1:0]        word_z;
  logic [RBG_W-1:0]     hit_word;

  logic [RBG_W-1:0]     mask_m;
  logic [ZW-1:0]        exp_x;
  logic [ZW-1:0]        exp_s;

  // Part geometry: size, nominal RBG size, alignment offset, RBG count
  always_comb begin
    size_s = cfg_i.bwp_size;
    if (size_s == '0) begin
      size_s = PRB_IDX_W'(1);
    end else if (size_s > PRB_IDX_W'(MAX_PRBS)) begin
      size_s = PRB_IDX_W'(MAX_PRBS);
    end
    priority if (size_s <= SIZE_TH0) begin
      lp = cfg_i.rbg_config1 ? LP_W'(1) : LP_W'(2);
    end else if (size_s <= SIZE_TH1) begin
      lp = cfg_i.rbg_config1 ? LP_W'(2) : LP_W'(3);
    end else if (size_s <= SIZE_TH2) begin
      lp = cfg_i.rbg_config1 ? LP_W'(3) : LP_W'(4);
    end else begin
      lp = LP_W'(4);
    end
    p_w      = (OFF_W+1)'(1) << lp;
    off      = cfg_i.bwp_first_prb[OFF_W-1:0] & (p_w[OFF_W-1:0] - OFF_W'(1));
    span     = 10'(size_s) + 10'(off) + 10'(p_w) - 10'd1;
    nrbg_raw = span >> lp;
    nrbg     = (nrbg_raw > 10'(MAX_RBGS)) ? RBG_CNT_W'(MAX_RBGS) : nrbg_raw[RBG_CNT_W-1:0];
    for (int r = 0; r < int'(RBG_W); r++) begin
      rbg_ok[r] = RBG_CNT_W'(r) < nrbg;
    end
    for (int q = 0; q < int'(NB); q++) begin
      prb_ok[q] = PRB_IDX_W'(q) < size_s;
    end
  end

  // Interval grant: RBGs from the first to the last covered one
  always_comb begin
    end_c = (req_i.prb_end > size_s) ? size_s : req_i.prb_end;
    r0    = (10'(req_i.prb_first) + 10'(off)) >> lp;
    r1    = (10'(end_c) - 10'd1 + 10'(off)) >> lp;
    for (int r = 0; r < int'(RBG_W); r++) begin
      hit_int[r] = (req_i.prb_first < end_c) && (10'(r) >= r0) && (10'(r) <= r1);
    end
  end

  // Word grant: place the word, shift by the offset, OR each RBG chunk
  always_comb begin
    for (int w = 0; w < int'(NW); w++) begin
      word_v[w*64 +: 64] = (req_i.word_index == WIDX_W'(w)) ? req_i.grant_word : '0;
    end
    word_v = word_v & prb_ok;
    word_z = ZW'(word_v) << off;
    for (int r = 0; r < int'(RBG_W); r++) begin
      unique case (lp)
        LP_W'(2): hit_word[r] = |word_z[r*4 +: 4];
        LP_W'(3): hit_word[r] = |word_z[r*8 +: 8];
        LP_W'(4): hit_word[r] = |word_z[r*16 +: 16];
        default:  hit_word[r] = |word_z[r*2 +: 2];
      endcase
    end
  end

  // RBG mask grant: expand each mask bit over its chunk, then align
  always_comb begin
    mask_m = mask_i & rbg_ok;
    for (int k = 0; k < int'(ZW); k++) begin
      unique case (lp)
        LP_W'(2): exp_x[k] = ((k >> 2) < int'(RBG_W)) ? mask_m[(k >> 2) % RBG_W] : 1'b0;
        LP_W'(3): exp_x[k] = ((k >> 3) < int'(RBG_W)) ? mask_m[(k >> 3) % RBG_W] : 1'b0;
        LP_W'(4): exp_x[k] = ((k >> 4) < int'(RBG_W)) ? mask_m[(k >> 4) % RBG_W] : 1'b0;
        default:  exp_x[k] = ((k >> 1) < int'(RBG_W)) ? mask_m[(k >> 1) % RBG_W] : 1'b0;
      endcase
    end
    exp_s     = exp_x >> off;
    prb_set_o = exp_s[NB-1:0] & prb_ok;
  end

  always_comb begin
    unique case (req_i.req_type)
      REQ_INTERVAL: rbg_set_o = hit_int & rbg_ok;
      REQ_WORD:     rbg_set_o = hit_word & rbg_ok;
      REQ_RBG:      rbg_set_o = '0;
      REQ_READ:     rbg_set_o = '0;
      default:      rbg_set_o = '0;
    endcase
  end

endmodule

`default_nettype wire

@@ sv/prb_rbg_grant_bitmap_top.sv @@
`timescale 1ns / 1ps
`default_nettype none

// PRB / RBG grant bitmap for one bandwidth part (type-0 allocation).
//
// Command channel: an item transfers on a rising edge with start high and
// busy low. Grants update the opposite view: PRB intervals and PRB words
// mark the covering RBGs, an RBG mask marks the covered PRBs.
// Result channel: res_strobe_o is high for exactly one cycle with the RBG
// bitmap and the selected 64-PRB word in res_o; the receiver cannot stall,
// so every result is taken in that cycle.
// Sequence: PRB interval, PRB word and read items pass READ (one read of the
// selected word from the PRB memory), WAIT and RESP; a word index beyond the
// part goes straight to RESP with a zero word. RBG mask items stay in READ
// for all NW words: the PRB memory has one read and one write port, so each
// of the NW words is read, OR-ed with the expanded mask and written back.
// One item is in flight at a time; busy covers it up to its result cycle.
// Configuration: cfg_valid_i / cfg_ready_o write channel, always ready.
// It is to be used only while busy is low; the block does not enforce this.
// Config writes keep both bitmaps. Reset: both bitmaps read as zero (per-word
// valid bits), registers take their reset values, no clearing pass.

module prb_rbg_grant_bitmap_top #(
  parameter int unsigned MAX_PRBS = 275,
  parameter int unsigned MAX_RBGS = 19
) (
  input  wire logic                               clk_i,
  input  wire logic                               rst_ni,
  input  wire logic                               start,
  output logic                                    busy,
  input  wire prbg_pkg::req_t                     req_i,
  output logic                                    res_strobe_o,
  output prbg_pkg::res_t                          res_o,
  input  wire logic                               cfg_valid_i,
  output logic                                    cfg_ready_o,
  input  wire logic [prbg_pkg::CFG_IDX_W-1:0]     cfg_idx_i,
  input  wire logic [prbg_pkg::CFG_DATA_W-1:0]    cfg_data_i
);
  import prbg_pkg::*;

  localparam int unsigned NW = (MAX_PRBS + 63) / 64;
  localparam int unsigned NB = NW * 64;
  localparam int unsigned AW = (NW > 1) ? $clog2(NW) : 1;

  typedef enum logic [3:0] {
    ST_IDLE = 4'b0001,
    ST_READ = 4'b0010,
    ST_WAIT = 4'b0100,
    ST_RESP = 4'b1000
  } state_e;

  state_e state_q, state_d;

  cfg_t cfg_q;

  // Latched item
  req_type_e         type_q, type_d;
  logic [WIDX_W-1:0] widx_q, widx_d;
  logic [RBG_W-1:0]  mask_q, mask_d;

  // Bitmap state held outside the memory and the output word
  logic [RBG_W-1:0]  rbg_q, rbg_d;
  logic [WORD_W-1:0] out_word_q, out_word_d;

  // Memory walk: issue address, last address, returning address
  logic [AW-1:0] rd_addr_q, rd_addr_d;
  logic [AW-1:0] last_q, last_d;
  logic [AW-1:0] ra_q;
  logic          rv_q;

  logic              accept;
  logic [RBG_W-1:0]  rbg_set;
  logic [NB-1:0]     prb_set;
  logic [WORD_W-1:0] rd_data;
  logic [WORD_W-1:0] set_slice;
  logic [WORD_W-1:0] new_word;
  logic              wr_en;

  assign cfg_ready_o = 1'b1;
  assign accept      = start && !busy;
  assign busy        = (state_q != ST_IDLE);

  // Configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.bwp_size      <= BWP_SIZE_RST;
      cfg_q.bwp_first_prb <= BWP_FIRST_RST;
      cfg_q.rbg_config1   <= RBG_CFG1_RST;
    end else if (cfg_valid_i && cfg_ready_o) begin
      unique case (cfg_idx_i)
        CFG_BWP_SIZE:  cfg_q.bwp_size      <= cfg_data_i[PRB_IDX_W-1:0];
        CFG_BWP_FIRST: cfg_q.bwp_first_prb <= cfg_data_i[PRB_IDX_W-1:0];
        CFG_RBG_CFG1:  cfg_q.rbg_config1   <= cfg_data_i[0];
        default: ;
      endcase
    end
  end

  // RBG hits come from the live item, PRB marks from the latched mask
  prbg_map #(
    .MAX_PRBS (MAX_PRBS),
    .MAX_RBGS (MAX_RBGS)
  ) u_map (
    .cfg_i     (cfg_q),
    .req_i     (req_i),
    .mask_i    (mask_q),
    .rbg_set_o (rbg_set),
    .prb_set_o (prb_set)
  );

  // Merge the mask marks into the word coming back from memory
  always_comb begin
    set_slice = '0;
    for (int w = 0; w < int'(NW); w++) begin
      if (ra_q == AW'(w)) begin
        set_slice = prb_set[w*64 +: 64];
      end
    end
    wr_en    = rv_q && (type_q == REQ_RBG);
    new_word = rd_data | ((type_q == REQ_RBG) ? set_slice : '0);
  end

  prbg_ram #(
    .DEPTH (NW),
    .AW    (AW)
  ) u_ram (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .rd_en_i   (state_q == ST_READ),
    .rd_addr_i (rd_addr_q),
    .rd_data_o (rd_data),
    .wr_en_i   (wr_en),
    .wr_addr_i (ra_q),
    .wr_data_i (new_word)
  );

  // Sequencer
  always_comb begin
    state_d    = state_q;
    type_d     = type_q;
    widx_d     = widx_q;
    mask_d     = mask_q;
    rbg_d      = rbg_q;
    out_word_d = out_word_q;
    rd_addr_d  = rd_addr_q;
    last_d     = last_q;

    // Capture the selected word as it passes through
    if (rv_q && (widx_q == WIDX_W'(ra_q))) begin
      out_word_d = new_word;
    end

    unique case (state_q)
      ST_IDLE: begin
        if (accept) begin
          type_d     = req_i.req_type;
          widx_d     = req_i.word_index;
          mask_d     = req_i.grant_word[RBG_W-1:0];
          rbg_d      = rbg_q | rbg_set;
          out_word_d = '0;
          if (req_i.req_type == REQ_RBG) begin
            rd_addr_d = '0;
            last_d    = AW'(NW - 1);
            state_d   = ST_READ;
          end else if (req_i.word_index < WIDX_W'(NW)) begin
            rd_addr_d = req_i.word_index[AW-1:0];
            last_d    = req_i.word_index[AW-1:0];
            state_d   = ST_READ;
          end else begin
            state_d = ST_RESP;
          end
        end
      end
      ST_READ: begin
        if (rd_addr_q == last_q) begin
          state_d = ST_WAIT;
        end else begin
          rd_addr_d = rd_addr_q + AW'(1);
        end
      end
      ST_WAIT: begin
        state_d = ST_RESP;
      end
      ST_RESP: begin
        state_d = ST_IDLE;
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      rbg_q   <= '0;
      rv_q    <= 1'b0;
    end else begin
      state_q <= state_d;
      rbg_q   <= rbg_d;
      rv_q    <= (state_q == ST_READ);
    end
  end

  // Payload registers
  always_ff @(posedge clk_i) begin
    type_q     <= type_d;
    widx_q     <= widx_d;
    mask_q     <= mask_d;
    out_word_q <= out_word_d;
    rd_addr_q  <= rd_addr_d;
    last_q     <= last_d;
    ra_q       <= rd_addr_q;
  end

  assign res_strobe_o       = (state_q == ST_RESP);
  assign res_o.rbg_bits     = rbg_q;
  assign res_o.prb_word_out = out_word_q;

  // A result lasts one cycle and frees the block right after
  a_strobe_once: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_strobe_o |=> !res_strobe_o && !busy)
    else $error("result strobe held or block still busy after result");

  // Only mask grants write back into the PRB memory
  a_write_rbg_only: assert property (@(posedge clk_i) disable iff (!rst_ni)
    wr_en |-> (type_q == REQ_RBG) && (state_q == ST_READ || state_q == ST_WAIT))
    else $error("PRB memory write outside a mask grant walk");

  // An accepted item keeps the block busy on the next cycle
  a_accept_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept |=> busy)
    else $error("accepted item did not raise busy");

  // The RBG view only changes when an item transfers
  a_rbg_stable: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !accept |=> $stable(rbg_q))
    else $error("RBG bitmap changed without an accepted item");

endmodule

`default_nettype wire

@@ tb/prb_rbg_grant_bitmap_top_tb.sv @@
`timescale 1ns / 1ps

module prb_rbg_grant_bitmap_top_tb;
  import prbg_pkg::*;

  localparam int unsigned MAX_PRBS      = 275;
  localparam int unsigned MAX_RBGS      = 19;
  localparam int unsigned PRB_WORDS     = (MAX_PRBS + 63) / 64;
  localparam int unsigned STALL_LIMIT   = 1000;
  localparam int unsigned SETTLE_CYCLES = 20;
  localparam int unsigned PHASE_ITEMS   = 107;

  // The register map leaves index 3 unassigned; a write there must be harmless.
  localparam logic [CFG_IDX_W-1:0] CFG_SPARE = 2'd3;

  // Mirror of the block: both bitmap views plus the three registers. Every
  // accepted command produces exactly one expected view, checked in order.
  class grant_bitmap_predictor;
    logic [PRB_IDX_W-1:0] size_reg;
    logic [PRB_IDX_W-1:0] first_reg;
    logic                 cfg1_reg;
    logic [RBG_W-1:0]     rbg_view;
    logic [WORD_W-1:0]    prb_view [PRB_WORDS];
    res_t                 expected_views [$];
    int unsigned          mismatches;
    int unsigned          checked;

    function new();
      size_reg   = BWP_SIZE_RST;
      first_reg  = BWP_FIRST_RST;
      cfg1_reg   = RBG_CFG1_RST;
      rbg_view   = '0;
      foreach (prb_view[w]) prb_view[w] = '0;
      mismatches = 0;
      checked    = 0;
    endfunction

    function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
      case (idx)
        CFG_BWP_SIZE:  size_reg  = data;
        CFG_BWP_FIRST: first_reg = data;
        CFG_RBG_CFG1:  cfg1_reg  = data[0];
        default: ;
      endcase
    endfunction

    function void note_grant(req_t rq);
      int unsigned s, p, off, nrbg, size0;
      int unsigned first, fin, widx, g, g_last, lo, hi, prb;
      res_t view;
      // Effective part size: zero acts as one PRB, oversize saturates.
      s = size_reg;
      if (s == 0) s = 1;
      if (s > MAX_PRBS) s = MAX_PRBS;
      // Nominal RBG size from the part-size table.
      if (s <= SIZE_TH0)      p = cfg1_reg ? 2 : 4;
      else if (s <= SIZE_TH1) p = cfg1_reg ? 4 : 8;
      else if (s <= SIZE_TH2) p = cfg1_reg ? 8 : 16;
      else                    p = 16;
      off  = first_reg % p;
      nrbg = (s + off + p - 1) / p;
      if (nrbg > MAX_RBGS) nrbg = MAX_RBGS;
      size0 = p - off;
      first = rq.prb_first;
      fin   = rq.prb_end;
      widx  = rq.word_index;

      case (rq.req_type)
        REQ_INTERVAL: begin
          if (fin > s) fin = s;
          if (first < fin) begin
            g_last = (fin - 1 + off) / p;
            for (g = (first + off) / p; g <= g_last; g++)
              if (g < nrbg) rbg_view[g] = 1'b1;
          end
        end
        REQ_WORD: begin
          if (widx < PRB_WORDS) begin
            for (int unsigned b = 0; b < WORD_W; b++) begin
              prb = widx * 64 + b;
              if (rq.grant_word[b] && prb < s && (prb + off) / p < nrbg)
                rbg_view[(prb + off) / p] = 1'b1;
            end
          end
        end
        REQ_RBG: begin
          for (g = 0; g < nrbg; g++) begin
            if (rq.grant_word[g]) begin
              // RBG 0 always starts at PRB 0 and holds the short remainder.
              lo = (g == 0) ? 0 : (g - 1) * p + size0;
              hi = (g == 0) ? size0 : lo + p;
              if (hi > s) hi = s;
              for (prb = lo; prb < hi; prb++)
                if (prb < s && prb < MAX_PRBS) prb_view[prb / 64][prb % 64] = 1'b1;
            end
          end
        end
        default: ;
      endcase

      view.rbg_bits     = rbg_view;
      view.prb_word_out = (widx < PRB_WORDS) ? prb_view[widx] : '0;
      expected_views.push_back(view);
    endfunction

    function void check_view(res_t got);
      res_t want;
      if (expected_views.size() == 0) begin
        mismatches++;
        $display("%0t ns: result with nothing outstanding, rbg_bits %05h prb_word_out %016h",
                 $time, got.rbg_bits, got.prb_word_out);
        return;
      end
      want = expected_views.pop_front();
      checked++;
      if (got.rbg_bits !== want.rbg_bits) begin
        mismatches++;
        $display("%0t ns: rbg_bits expected %05h, got %05h",
                 $time, want.rbg_bits, got.rbg_bits);
      end
      if (got.prb_word_out !== want.prb_word_out) begin
        mismatches++;
        $display("%0t ns: prb_word_out expected %016h, got %016h",
                 $time, want.prb_word_out, got.prb_word_out);
      end
    endfunction
  endclass

  logic                  clk = 1'b0;
  logic                  rst_n;
  logic                  start;
  logic                  busy;
  req_t                  req;
  logic                  res_strobe;
  res_t                  res;
  logic                  cfg_valid;
  logic                  cfg_ready;
  logic [CFG_IDX_W-1:0]  cfg_idx;
  logic [CFG_DATA_W-1:0] cfg_data;

  grant_bitmap_predictor tracker;
  int unsigned           part_now;      // effective part size, steers stimulus
  int unsigned           kind_count [4];
  int unsigned           reg_writes;
  int unsigned           idle_cycles;

  prb_rbg_grant_bitmap_top u_dut (
    .clk_i        (clk),
    .rst_ni       (rst_n),
    .start        (start),
    .busy         (busy),
    .req_i        (req),
    .res_strobe_o (res_strobe),
    .res_o        (res),
    .cfg_valid_i  (cfg_valid),
    .cfg_ready_o  (cfg_ready),
    .cfg_idx_i    (cfg_idx),
    .cfg_data_i   (cfg_data)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Sample every transfer at the edge that completes it. The result check
  // runs first: at most one command is in flight, so any result seen here
  // belongs to a command accepted at an earlier edge.
  always @(posedge clk) begin
    if (rst_n) begin
      if (res_strobe) tracker.check_view(res);
      if (start && !busy) begin
        tracker.note_grant(req);
        kind_count[int'(req.req_type)]++;
      end
      if (cfg_valid && cfg_ready) begin
        tracker.write_reg(cfg_idx, cfg_data);
        reg_writes++;
      end
    end
  end

  // Watchdog: give up once nothing has moved on any channel for too long.
  always @(posedge clk) begin
    if ((start && !busy) || res_strobe || (cfg_valid && cfg_ready))
      idle_cycles <= 0;
    else
      idle_cycles <= idle_cycles + 1;
    if (idle_cycles == STALL_LIMIT) begin
      $display("%0t ns: no transfer for %0d cycles", $time, STALL_LIMIT);
      $display("SCOREBOARD MISMATCH");
      $finish;
    end
  end

  // Present one command and hold it until the edge that accepts it. Call
  // right after a rising edge; returns right after the accepting edge with
  // start still high, so a back-to-back command can follow directly.
  task automatic issue(req_t r);
    start <= 1'b1;
    req   <= r;
    @(posedge clk);
    while (busy) @(posedge clk);
  endtask

  // Drop start and wait until every outstanding result has come back.
  task automatic drain();
    start <= 1'b0;
    @(posedge clk);
    while (tracker.expected_views.size() != 0 || busy) @(posedge clk);
  endtask

  // Write one register; hold valid high when another write follows directly.
  task automatic program_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data,
                             bit hold);
    cfg_valid <= 1'b1;
    cfg_idx   <= idx;
    cfg_data  <= data;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    if (!hold) cfg_valid <= 1'b0;
    if (idx == CFG_BWP_SIZE)
      part_now = (data == 0) ? 1 : (data > MAX_PRBS) ? MAX_PRBS : data;
  endtask

  function automatic req_t make_req(req_type_e kind, int unsigned first, int unsigned fin,
                                    int unsigned widx, logic [WORD_W-1:0] word);
    req_t r;
    r.req_type   = kind;
    r.prb_first  = PRB_IDX_W'(first);
    r.prb_end    = PRB_IDX_W'(fin);
    r.word_index = WIDX_W'(widx);
    r.grant_word = word;
    return r;
  endfunction

  // Random command. Bitmaps only ever accumulate, so grants are kept narrow
  // (short intervals, few PRB bits, single RBGs) and half the traffic is
  // plain reads; that way the views fill up slowly and stay informative.
  function automatic req_t random_request();
    req_t        r;
    int unsigned pick;
    r.req_type   = REQ_READ;
    r.prb_first  = PRB_IDX_W'($urandom_range(0, 511));
    r.prb_end    = PRB_IDX_W'($urandom_range(0, 511));
    r.word_index = WIDX_W'(($urandom_range(0, 9) == 0) ? $urandom_range(5, 7)
                                                        : $urandom_range(0, 4));
    r.grant_word = {$urandom, $urandom};
    pick = $urandom_range(0, 99);
    if (pick < 50) begin
      r.req_type = REQ_READ;
    end else if (pick < 67) begin
      r.req_type = REQ_INTERVAL;
      if ($urandom_range(0, 9) != 0) begin
        r.prb_first = PRB_IDX_W'($urandom_range(0, part_now - 1));
        r.prb_end   = PRB_IDX_W'(r.prb_first + $urandom_range(1, 6));
      end
    end else if (pick < 84) begin
      r.req_type = REQ_WORD;
      if ($urandom_range(0, 9) != 0) begin
        r.word_index = WIDX_W'($urandom_range(0, (part_now - 1) / 64));
        r.grant_word = (64'd1 << $urandom_range(0, 63)) |
                       (($urandom_range(0, 3) == 0) ? (64'd1 << $urandom_range(0, 63)) : '0);
      end
    end else begin
      r.req_type = REQ_RBG;
      // Bits above the RBG field are don't-care; keep them random.
      if ($urandom_range(0, 19) != 0)
        r.grant_word = {r.grant_word[WORD_W-1:RBG_W], RBG_W'(0)} |
                       (64'd1 << $urandom_range(0, RBG_W - 1));
    end
    return r;
  endfunction

  // One register setting's worth of random traffic, sent in bursts with
  // random gaps; a third of the gaps are zero so long unbroken runs occur.
  task automatic run_phase(int unsigned items);
    int unsigned burst_left;
    int unsigned gap;
    burst_left = $urandom_range(1, 40);
    for (int unsigned n = 0; n < items; n++) begin
      if (n != 0 && burst_left == 0) begin
        gap = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 12);
        if (gap != 0) begin
          start <= 1'b0;
          repeat (gap) @(posedge clk);
        end
        burst_left = $urandom_range(1, 40);
      end
      issue(random_request());
      burst_left--;
      // Halfway through, hold off until the block has answered everything.
      if (n == items / 2) drain();
    end
    drain();
  endtask

  int unsigned phase_size [12] = '{7, 36, 37, 72, 73, 100, 144, 145, 230, 275, 511, 0};

  initial begin
    int unsigned first_prb;
    tracker     = new();
    part_now    = MAX_PRBS;
    reg_writes  = 0;
    foreach (kind_count[k]) kind_count[k] = 0;
    rst_n     <= 1'b0;
    start     <= 1'b0;
    req       <= '0;
    cfg_valid <= 1'b0;
    cfg_idx   <= CFG_BWP_SIZE;
    cfg_data  <= '0;
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Reset setting: 275 PRBs, RBG size 16, 18 RBGs. Start from empty maps,
    // then probe the part edges, empty intervals and out-of-range words.
    issue(make_req(REQ_READ, 0, 0, 0, '0));
    issue(make_req(REQ_READ, 511, 511, 7, '1));
    issue(make_req(REQ_INTERVAL, 0, 1, 0, '0));
    issue(make_req(REQ_INTERVAL, 274, 511, 4, '0));      // end clamps to part
    issue(make_req(REQ_INTERVAL, 300, 511, 4, '0));      // empty after clamp
    issue(make_req(REQ_INTERVAL, 10, 10, 0, '0));        // empty interval
    issue(make_req(REQ_WORD, 0, 0, 4, (64'd1 << 18) | (64'd1 << 63)));
    issue(make_req(REQ_WORD, 0, 0, 7, '1));              // word beyond part
    issue(make_req(REQ_WORD, 0, 0, 5, '1));
    issue(make_req(REQ_RBG, 0, 0, 4, 64'hFFFF_FFFF_FFFE_0000)); // only RBG 17 exists
    issue(make_req(REQ_RBG, 0, 0, 0, 64'd1));
    drain();

    // Single-PRB part with a wrapped start: everything collapses onto PRB 0.
    program_reg(CFG_BWP_SIZE, 9'd1, 1'b1);
    program_reg(CFG_BWP_FIRST, 9'h1FF, 1'b1);
    program_reg(CFG_RBG_CFG1, 9'h1FE, 1'b1);
    program_reg(CFG_SPARE, 9'h1FF, 1'b0);
    @(posedge clk);
    issue(make_req(REQ_WORD, 0, 0, 0, '1));
    issue(make_req(REQ_RBG, 0, 0, 0, '1));
    issue(make_req(REQ_INTERVAL, 0, 511, 0, '0));
    drain();

    // Zero size acts as one PRB.
    program_reg(CFG_BWP_SIZE, 9'd0, 1'b1);
    program_reg(CFG_BWP_FIRST, 9'd274, 1'b0);
    @(posedge clk);
    issue(make_req(REQ_INTERVAL, 0, 2, 0, '0));
    drain();

    // Oversize part saturates to 275; offset 15 gives a one-PRB RBG 0 and
    // pushes the RBG count to its limit.
    program_reg(CFG_BWP_SIZE, 9'h1FF, 1'b1);
    program_reg(CFG_BWP_FIRST, 9'd15, 1'b1);
    program_reg(CFG_RBG_CFG1, 9'h001, 1'b0);
    @(posedge clk);
    issue(make_req(REQ_RBG, 0, 0, 4, (64'd1 << 18) | 64'd3));
    issue(make_req(REQ_READ, 0, 0, 0, '0));
    issue(make_req(REQ_INTERVAL, 1, 2, 0, '0));
    issue(make_req(REQ_WORD, 0, 0, 4, 64'd1 << 18));
    drain();

    // Random traffic across table boundaries and both RBG configurations.
    for (int unsigned i = 0; i < 12; i++) begin
      case (i % 4)
        0:       first_prb = 0;
        1:       first_prb = 511;
        2:       first_prb = 274;
        default: first_prb = $urandom_range(0, 511);
      endcase
      program_reg(CFG_BWP_SIZE, CFG_DATA_W'(phase_size[i]), 1'b1);
      program_reg(CFG_BWP_FIRST, CFG_DATA_W'(first_prb), 1'b1);
      program_reg(CFG_RBG_CFG1,
                  {(CFG_DATA_W-1)'($urandom_range(0, 255)), 1'(i % 2)}, 1'b0);
      @(posedge clk);
      run_phase(PHASE_ITEMS);
    end

    repeat (SETTLE_CYCLES) @(posedge clk);
    if (tracker.expected_views.size() != 0) begin
      $display("%0t ns: %0d results never arrived", $time, tracker.expected_views.size());
      tracker.mismatches += tracker.expected_views.size();
    end

    $display("Covered %0d commands: %0d interval, %0d PRB word, %0d RBG mask, %0d read",
             kind_count[0] + kind_count[1] + kind_count[2] + kind_count[3],
             kind_count[0], kind_count[1], kind_count[2], kind_count[3]);
    $display("%0d register writes, %0d results compared, %0d field errors",
             reg_writes, tracker.checked, tracker.mismatches);
    if (tracker.mismatches == 0)
      $display("SCOREBOARD CLEAN");
    else
      $display("SCOREBOARD MISMATCH");
    $finish;
  end

endmodule
